// ----- design/gsa_pkg.sv -----
// Shared types and constants for the generational slot allocator.
`timescale 1ns / 1ps

package gsa_pkg;

   localparam int unsigned CAPACITY_DEF = 1024;
   localparam int          GEN_W        = 32;
   localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_LOOKUP = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_STALE     = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] slot;
      logic [63:0] handle;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] new_handle;
      logic [9:0]  found_slot;
      logic [10:0] free_slots;
   } rsp_type;

endpackage

// ----- design/generational_slot_allocator.sv -----
// Slot handle allocator: LIFO free stack with per-slot generation counters.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | gsa_pkg::req_type
//   rsp_    | out       | rsp_valid / rsp_stall | gsa_pkg::rsp_type
//
// One item per cycle while the result is not stalled; an item passes the input
// register and generation-table read, then the result register.
// The free list is a stack of {slot, generation} with the top two entries
// held in registers; never-touched slots form an implicit tail counted by
// a fill pointer, so reset needs no clearing pass.
// A stalled result holds the item behind it; the input stalls only then.
`timescale 1ns / 1ps

module generational_slot_allocator #(
   parameter int unsigned CAPACITY = gsa_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gsa_pkg::rsp_type rsp_data
);
   import gsa_pkg::*;

   localparam int SLOT_W  = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = SLOT_W + GEN_W;
   localparam int TAB_W   = GEN_W + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [31:0]      CAP_32  = 32'(CAPACITY);

   // handshake
   logic              req_valid_ff;
   req_type           req_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              advance;
   logic              exec;
   logic              accept;

   // free stack
   logic [ENTRY_W-1:0] stack_mem [CAPACITY];
   logic [CNT_W-1:0]   cnt_ff;
   logic [ENTRY_W-1:0] top_ff;
   logic [ENTRY_W-1:0] second_ff;
   logic [CNT_W-1:0]   fresh_ff;
   logic [CNT_W-1:0]   free_ff;

   // generation table: {in_use, generation}
   logic [TAB_W-1:0]   gen_mem [CAPACITY];
   logic [TAB_W-1:0]   gen_rd_ff;
   logic [SLOT_W-1:0]  rd_addr_in;

   // execute stage
   logic [SLOT_W-1:0]  cur_idx;
   logic               cur_touched;
   logic [TAB_W-1:0]   cur_entry;
   logic               cur_used;
   logic [GEN_W-1:0]   cur_gen;
   logic               slot_ok;
   logic               look_ok;
   logic               from_stack;
   logic               from_fresh;
   logic [ENTRY_W-1:0] pop_entry;
   logic [SLOT_W-1:0]  pop_slot;
   logic [GEN_W-1:0]   pop_gen;
   logic [ENTRY_W-1:0] push_entry;
   logic [SLOT_W-1:0]  pop_rd_addr;
   logic               do_pop;
   logic               do_push;
   logic               gen_we;
   logic [SLOT_W-1:0]  gen_wa;
   logic [TAB_W-1:0]   gen_wd;
   logic [CNT_W-1:0]   free_in;
   rsp_type            rsp_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign exec      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_addr_in = (req_data.kind == KIND_FREE) ? req_data.slot[SLOT_W-1:0]
                                                    : req_data.handle[SLOT_W-1:0];

   assign cur_idx     = (req_ff.kind == KIND_FREE) ? req_ff.slot[SLOT_W-1:0]
                                                   : req_ff.handle[SLOT_W-1:0];
   assign cur_touched = CNT_W'(cur_idx) < fresh_ff;
   assign cur_entry   = cur_touched ? gen_rd_ff : {1'b0, GEN_INIT};
   assign cur_used    = cur_entry[GEN_W];
   assign cur_gen     = cur_entry[GEN_W-1:0];
   assign slot_ok     = req_ff.slot < CAP_32;
   assign look_ok     = req_ff.handle[31:0] < CAP_32;

   assign from_stack  = cnt_ff != '0;
   assign from_fresh  = fresh_ff != CAP_CNT;
   assign pop_entry   = from_stack ? top_ff : {fresh_ff[SLOT_W-1:0], GEN_INIT};
   assign pop_slot    = pop_entry[ENTRY_W-1:GEN_W];
   assign pop_gen     = pop_entry[GEN_W-1:0];
   assign push_entry  = {req_ff.slot[SLOT_W-1:0], cur_gen + GEN_W'(1)};
   assign pop_rd_addr = SLOT_W'(cnt_ff - CNT_W'(3));

   always_comb begin
      rsp_in            = '0;
      rsp_in.status     = ST_OK;
      do_pop            = 1'b0;
      do_push           = 1'b0;
      gen_we            = 1'b0;
      gen_wa            = cur_idx;
      gen_wd            = {1'b0, cur_gen + GEN_W'(1)};
      free_in           = free_ff;
      unique case (req_ff.kind)
         KIND_ALLOC: begin
            if (from_stack || from_fresh) begin
               do_pop            = 1'b1;
               gen_we            = 1'b1;
               gen_wa            = pop_slot;
               gen_wd            = {1'b1, pop_gen};
               free_in           = free_ff - CNT_W'(1);
               rsp_in.new_handle = {pop_gen, 32'(pop_slot)};
               rsp_in.found_slot = 10'(pop_slot);
            end else begin
               rsp_in.status = ST_EXHAUSTED;
            end
         end
         KIND_FREE: begin
            if (slot_ok && cur_used) begin
               do_push = 1'b1;
               gen_we  = 1'b1;
               free_in = free_ff + CNT_W'(1);
            end else begin
               rsp_in.status = ST_BAD_FREE;
            end
         end
         KIND_LOOKUP: begin
            if (look_ok && cur_gen == req_ff.handle[63:32]) begin
               rsp_in.found_slot = 10'(req_ff.handle[31:0]);
            end else begin
               rsp_in.status = ST_STALE;
            end
         end
         default: begin
         end
      endcase
      rsp_in.free_slots = 11'(free_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         fresh_ff     <= '0;
         free_ff      <= CAP_CNT;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (exec) begin
            free_ff <= free_in;
            if (do_pop && from_stack) begin
               cnt_ff <= cnt_ff - CNT_W'(1);
            end else if (do_pop) begin
               fresh_ff <= fresh_ff + CNT_W'(1);
            end else if (do_push) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // stack: top two entries in registers, full copy in memory
   always_ff @(posedge clock) begin
      if (exec && do_push) begin
         stack_mem[cnt_ff[SLOT_W-1:0]] <= push_entry;
         top_ff                        <= push_entry;
         second_ff                     <= top_ff;
      end else if (exec && do_pop && from_stack) begin
         top_ff    <= second_ff;
         second_ff <= stack_mem[pop_rd_addr];
      end
   end

   // generation table with write-to-read bypass
   always_ff @(posedge clock) begin
      if (exec && gen_we) begin
         gen_mem[gen_wa] <= gen_wd;
      end
      if (accept) begin
         if (exec && gen_we && gen_wa == rd_addr_in) begin
            gen_rd_ff <= gen_wd;
         end else begin
            gen_rd_ff <= gen_mem[rd_addr_in];
         end
      end
   end

endmodule
